// ===== hw/rtl/twga_pkg.sv =====
// ----------------------------------------------------------------------------
// twga_pkg
// shared types and constants of the tumbling window group average block
// ----------------------------------------------------------------------------
package twga_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned TsW = 43;
  localparam int unsigned EndW = 44;
  localparam int unsigned SymW = 20;
  localparam logic [31:0] WinLenReset = 32'd1000;
  localparam logic FuncTrade = 1'b0;
  localparam logic FuncFlush = 1'b1;
  localparam logic StatusRow = 1'b0;
  localparam logic StatusDrop = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_SCAN, ST_HREAD, ST_UPD, ST_DROP,
    ST_FSCAN, ST_FREAD, ST_FLOAD, ST_DIV, ST_FOUT, ST_CLR
  } state_e;

  typedef struct packed {
    logic [0:0] func;
    logic [0:0] trade_flag;
    logic [TsW-1:0] timestamp;
    logic [SymW-1:0] symbol;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [0:0] status;
    logic [TsW-1:0] win_start;
    logic [EndW-1:0] win_end;
    logic [SymW-1:0] group_symbol;
    logic signed [31:0] average;
    logic [31:0] event_count;
    logic [0:0] last;
  } out_item_t;
endpackage

// ===== hw/rtl/twga_if.sv =====
// ----------------------------------------------------------------------------
// twga_if
// valid/ready channel interfaces for items, results and configuration
// ----------------------------------------------------------------------------
interface twga_in_if import twga_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface twga_out_if import twga_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface twga_cfg_if ();
  logic valid;
  logic ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tumbling_window_group_average_top.sv =====
// ----------------------------------------------------------------------------
// tumbling_window_group_average_top
// groups trades by window and symbol, flushes averages in key order
// ----------------------------------------------------------------------------
// channel  dir  contents
// in_i     in   func, trade_flag, timestamp, symbol, value
// out_o    out  status, win_start, win_end, group_symbol, average, ...
// cfg_i    in   window_length
// trade: a bit-serial remainder, a key search (one registered table read a cycle),
// then a read and an update step. flush: per row a min scan, a read and a load
// step, a shift-subtract divide and one output step; then a clear of valid bits.
// ignored events and flushes of an empty table leave the sequencer idle.
// reset clears valid bits and the fill count; output stalls hold the sequencer.
module tumbling_window_group_average_top import twga_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  twga_in_if.sink in_i,
  twga_out_if.source out_o,
  twga_cfg_if.sink cfg_i
);
  logic [SymW-1:0] mem_sym [TableEntries];
  logic [EndW-1:0] mem_win [TableEntries];
  logic signed [63:0] mem_sum [TableEntries];
  logic [31:0] mem_cnt [TableEntries];

  state_e state_q, state_d;
  logic [TableEntries-1:0] valid_q, done_q;
  logic [CntW-1:0] used_q, emitted_q;
  logic [31:0] winlen_q;
  in_item_t item_q;
  logic [TsW-1:0] rem_q;
  logic [5:0] bit_q;
  logic [IdxW:0] scan_q;
  logic hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic best_ok_q;
  logic [IdxW-1:0] best_q;
  logic [EndW+SymW-1:0] best_key_q;
  logic [EndW-1:0] rd_win_q;
  logic [SymW-1:0] rd_sym_q;
  logic signed [63:0] rd_sum_q;
  logic [31:0] rd_cnt_q;
  logic [63:0] quo_q, dvd_q;
  logic [32:0] drem_q;
  logic [6:0] dstep_q;
  out_item_t out_q;
  logic out_v_q;

  logic [IdxW-1:0] si;
  logic [IdxW-1:0] pidx;
  logic [IdxW-1:0] raddr;
  logic [EndW-1:0] start_w;
  logic [TsW:0] rem_sh;
  logic [EndW+SymW-1:0] ekey;
  logic [32:0] dtry;
  logic signed [63:0] newsum;
  logic [63:0] qneg;
  logic signed [63:0] qs;

  assign si = scan_q[IdxW-1:0];
  assign pidx = si - 1'b1;
  assign start_w = {1'b0, item_q.timestamp - rem_q};
  assign rem_sh = {rem_q, item_q.timestamp[bit_q]};
  assign ekey = {rd_win_q, rd_sym_q};
  assign dtry = {drem_q[31:0], dvd_q[63]} - {1'b0, rd_cnt_q};
  assign newsum = rd_sum_q + 64'(signed'(item_q.value));
  assign qneg = rd_sum_q[63] ? (~quo_q + 64'd1) : quo_q;
  assign qs = signed'(qneg);

  assign in_i.ready = (state_q == ST_IDLE) && !out_v_q;
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = out_v_q;
  assign out_o.data = out_q;

  always_comb begin
    unique case (state_q)
      ST_HREAD: raddr = hit_idx_q;
      ST_FREAD, ST_FLOAD, ST_DIV, ST_FOUT: raddr = best_q;
      default: raddr = si;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid && in_i.ready) begin
        if (in_i.data.func == FuncFlush) state_d = (used_q == '0) ? ST_IDLE : ST_FSCAN;
        else if (in_i.data.trade_flag == 1'b1) state_d = ST_MOD;
      end
      ST_MOD: if (bit_q == '0) state_d = ST_SCAN;
      ST_SCAN: if (scan_q == (IdxW+1)'(TableEntries)) state_d = ST_HREAD;
      ST_HREAD: state_d = ST_UPD;
      ST_UPD: state_d = (!hit_q && (!free_q || used_q >= CntW'(TableEntries)))
                        ? ST_DROP : ST_IDLE;
      ST_DROP: if (!out_v_q) state_d = ST_IDLE;
      ST_FSCAN: if (scan_q == (IdxW+1)'(TableEntries)) state_d = ST_FREAD;
      ST_FREAD: state_d = ST_FLOAD;
      ST_FLOAD: state_d = ST_DIV;
      ST_DIV: if (dstep_q == 7'd64) state_d = ST_FOUT;
      ST_FOUT: if (!out_v_q) state_d = (emitted_q + 1'b1 == used_q) ? ST_CLR : ST_FSCAN;
      ST_CLR: if (scan_q == (IdxW+1)'(TableEntries - 1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      used_q <= '0;
      winlen_q <= WinLenReset;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) winlen_q <= cfg_i.data;
      if (out_v_q && out_o.ready) out_v_q <= 1'b0;
      if (state_q == ST_UPD && state_d == ST_IDLE && !hit_q) begin
        valid_q[free_idx_q] <= 1'b1;
        used_q <= used_q + 1'b1;
      end
      if (state_q == ST_DROP && !out_v_q) out_v_q <= 1'b1;
      if (state_q == ST_FOUT && !out_v_q) out_v_q <= 1'b1;
      if (state_q == ST_CLR) begin
        valid_q[si] <= 1'b0;
        if (state_d == ST_IDLE) used_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_win_q <= mem_win[raddr];
    rd_sym_q <= mem_sym[raddr];
    rd_sum_q <= mem_sum[raddr];
    rd_cnt_q <= mem_cnt[raddr];
    unique case (state_q)
      ST_IDLE: begin
        item_q <= in_i.data;
        rem_q <= '0;
        bit_q <= 6'(TsW - 1);
        scan_q <= '0;
        hit_q <= 1'b0;
        free_q <= 1'b0;
        hit_idx_q <= '0;
        free_idx_q <= '0;
        best_q <= '0;
        done_q <= '0;
        emitted_q <= '0;
        best_ok_q <= 1'b0;
      end
      ST_MOD: begin
        if (winlen_q == '0)
          rem_q <= '0;
        else if (rem_sh >= {12'd0, winlen_q})
          rem_q <= TsW'(rem_sh - {12'd0, winlen_q});
        else
          rem_q <= rem_sh[TsW-1:0];
        bit_q <= bit_q - 1'b1;
      end
      ST_SCAN: begin
        // compare the entry read in the previous cycle
        if (scan_q != '0 && valid_q[pidx] && rd_win_q == start_w &&
            rd_sym_q == item_q.symbol) begin
          hit_q <= 1'b1;
          hit_idx_q <= pidx;
        end
        if (!scan_q[IdxW] && !valid_q[si] && !free_q) begin
          free_q <= 1'b1;
          free_idx_q <= si;
        end
        scan_q <= scan_q + 1'b1;
      end
      ST_UPD: begin
        if (hit_q) begin
          if (item_q.value > 0 && !rd_sum_q[63] && newsum[63])
            mem_sum[hit_idx_q] <= 64'h7FFF_FFFF_FFFF_FFFF;
          else if (item_q.value < 0 && rd_sum_q[63] && !newsum[63])
            mem_sum[hit_idx_q] <= 64'h8000_0000_0000_0000;
          else mem_sum[hit_idx_q] <= newsum;
          if (rd_cnt_q != '1) mem_cnt[hit_idx_q] <= rd_cnt_q + 1'b1;
        end else if (state_d == ST_IDLE) begin
          mem_win[free_idx_q] <= start_w;
          mem_sym[free_idx_q] <= item_q.symbol;
          mem_sum[free_idx_q] <= 64'(signed'(item_q.value));
          mem_cnt[free_idx_q] <= 32'd1;
        end
        out_q.status <= StatusDrop;
        out_q.win_start <= start_w[TsW-1:0];
        out_q.win_end <= start_w + EndW'(winlen_q);
        out_q.group_symbol <= item_q.symbol;
        out_q.average <= '0;
        out_q.event_count <= '0;
        out_q.last <= 1'b0;
      end
      ST_FSCAN: begin
        if (scan_q != '0 && valid_q[pidx] && !done_q[pidx] &&
            (!best_ok_q || ekey < best_key_q)) begin
          best_ok_q <= 1'b1;
          best_q <= pidx;
          best_key_q <= ekey;
        end
        scan_q <= (state_d == ST_FREAD) ? '0 : scan_q + 1'b1;
      end
      ST_FREAD: begin
        drem_q <= '0;
        quo_q <= '0;
        dstep_q <= '0;
        done_q[best_q] <= 1'b1;
      end
      ST_FLOAD: dvd_q <= rd_sum_q[63] ? (~rd_sum_q + 64'd1) : rd_sum_q;
      ST_DIV: if (dstep_q != 7'd64) begin
        if (!dtry[32]) begin
          drem_q <= dtry;
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          drem_q <= {drem_q[31:0], dvd_q[63]};
          quo_q <= {quo_q[62:0], 1'b0};
        end
        dvd_q <= {dvd_q[62:0], 1'b0};
        dstep_q <= dstep_q + 1'b1;
      end
      ST_FOUT: if (!out_v_q) begin
        out_q.status <= StatusRow;
        out_q.win_start <= rd_win_q[TsW-1:0];
        out_q.win_end <= rd_win_q + EndW'(winlen_q);
        out_q.group_symbol <= rd_sym_q;
        out_q.average <= (qs > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                         (qs < -64'sd2147483648) ? 32'sh8000_0000 : qs[31:0];
        out_q.event_count <= rd_cnt_q;
        out_q.last <= (emitted_q + 1'b1 == used_q);
        emitted_q <= emitted_q + 1'b1;
        best_ok_q <= 1'b0;
        scan_q <= '0;
      end
      ST_CLR: scan_q <= scan_q + 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/twga_checker.sv =====
// ----------------------------------------------------------------------------
// twga_checker
// port-level checks of the tumbling window group average block
// ----------------------------------------------------------------------------
module twga_checker import twga_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("in ready with pending row");
  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status == StatusDrop |->
    out_data.last == 1'b0 && out_data.event_count == '0) else $error("drop row");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !out_valid) else $error("accept with pending row");
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown(out_data)) else $error("unknown row");
endmodule

bind tumbling_window_group_average_top twga_checker u_twga_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);

// ===== test/tumbling_window_group_average_top_tb.sv =====
// ----------------------------------------------------------------------------
// tumbling_window_group_average_top_tb
// self-checking regression of the tumbling window group average block: trades
// and flushes with random idling on both channels, results checked against
// an in-bench model of the group table, window length changed between phases
// ----------------------------------------------------------------------------
module tumbling_window_group_average_top_tb;
  import twga_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 300;

  logic clk_i;
  logic rst_ni;
  bit no_idle;
  int unsigned errors;
  int unsigned quiet_cycles;

  twga_in_if in_bus ();
  twga_out_if out_bus ();
  twga_cfg_if cfg_bus ();

  tumbling_window_group_average_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // group table model
  bit grp_valid[TableEntries];
  logic [EndW-1:0] grp_window[TableEntries];
  logic [SymW-1:0] grp_symbol[TableEntries];
  logic signed [63:0] grp_sum[TableEntries];
  logic [31:0] grp_count[TableEntries];
  int unsigned grp_used;
  logic [31:0] win_len;
  out_item_t pending_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #4ns clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [31:0] group_mean(int i);
    longint q;
    q = grp_sum[i] / longint'({32'b0, grp_count[i]});
    if (q > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (q < -longint'(64'sh80000000)) return 32'sh80000000;
    return q[31:0];
  endfunction

  task automatic predict_groups(in_item_t it);
    logic [63:0] ts64;
    logic [63:0] start;
    logic signed [63:0] total;
    out_item_t row;
    bit done[TableEntries];
    int hit;
    int free_slot;
    int best;
    int n_valid;
    if (it.func == FuncFlush) begin
      n_valid = 0;
      foreach (grp_valid[i]) begin
        done[i] = 0;
        if (grp_valid[i]) n_valid++;
      end
      for (int n = 0; n < n_valid; n++) begin
        best = -1;
        foreach (grp_valid[i]) begin
          if (grp_valid[i] && !done[i]) begin
            if (best < 0 || {grp_window[i], grp_symbol[i]} < {grp_window[best], grp_symbol[best]})
              best = i;
          end
        end
        done[best] = 1;
        row = '0;
        row.status = StatusRow;
        row.win_start = grp_window[best][TsW-1:0];
        row.win_end = grp_window[best] + {12'b0, win_len};
        row.group_symbol = grp_symbol[best];
        row.average = group_mean(best);
        row.event_count = grp_count[best];
        row.last = (n + 1 == n_valid);
        pending_rows.insert(pending_rows.size(), row);
      end
      foreach (grp_valid[i]) grp_valid[i] = 0;
      grp_used = 0;
      return;
    end
    if (!it.trade_flag) return;
    ts64 = {21'b0, it.timestamp};
    if (win_len == '0) start = ts64;
    else start = ts64 - (ts64 % {32'b0, win_len});
    hit = -1;
    free_slot = -1;
    foreach (grp_valid[i]) begin
      if (grp_valid[i]) begin
        if (grp_window[i] == start[EndW-1:0] && grp_symbol[i] == it.symbol) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0 || grp_used >= TableEntries) begin
        row = '0;
        row.status = StatusDrop;
        row.win_start = start[TsW-1:0];
        row.win_end = start[EndW-1:0] + {12'b0, win_len};
        row.group_symbol = it.symbol;
        pending_rows.insert(pending_rows.size(), row);
        return;
      end
      hit = free_slot;
      grp_valid[hit] = 1;
      grp_window[hit] = start[EndW-1:0];
      grp_symbol[hit] = it.symbol;
      grp_sum[hit] = 0;
      grp_count[hit] = 0;
      grp_used++;
    end
    total = grp_sum[hit] + 64'(signed'(it.value));
    if (it.value > 0 && total < grp_sum[hit]) total = 64'sh7fffffffffffffff;
    if (it.value < 0 && total > grp_sum[hit]) total = 64'sh8000000000000000;
    grp_sum[hit] = total;
    if (grp_count[hit] != 32'hffffffff) grp_count[hit]++;
  endtask

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= it;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_groups(it);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window_length(logic [31:0] len);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= len;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    win_len = len;
  endtask

  function automatic in_item_t make_trade(logic [TsW-1:0] ts, logic [SymW-1:0] sym,
                                          logic [31:0] val);
    in_item_t it;
    it.func = FuncTrade;
    it.trade_flag = 1'b1;
    it.timestamp = ts;
    it.symbol = sym;
    it.value = val;
    return it;
  endfunction

  function automatic in_item_t make_flush();
    in_item_t it;
    it = make_trade(43'({$urandom, $urandom}), 20'($urandom), $urandom);
    it.func = FuncFlush;
    it.trade_flag = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic test_extremes();
    in_item_t it;
    send_item(make_flush());
    send_item(make_trade('0, '0, 32'h7fffffff));
    send_item(make_trade(43'd999, '0, 32'h7fffffff));
    send_item(make_trade('1, '1, 32'h80000000));
    send_item(make_trade('1, '1, 32'h80000000));
    send_item(make_trade(43'd1000, 20'h55555, 32'hffffffff));
    send_item(make_trade(43'd1500, 20'h55555, 32'h00000002));
    it = make_trade('1, 20'haaaaa, 32'h12345678);
    it.trade_flag = 1'b0;
    send_item(it);
    send_item(make_flush());
    send_item(make_flush());
    write_window_length(32'd1);
    send_item(make_trade(43'h2aaaaaaaaaa, 20'h0f0f0, 32'h00010000));
    send_item(make_trade(43'h55555555555, 20'hf0f0f, 32'hfffeffff));
    send_item(make_flush());
    write_window_length(32'hffffffff);
    send_item(make_trade('1, '1, 32'h7fffffff));
    send_item(make_trade(43'hfffffffe, '1, 32'h00000001));
    send_item(make_trade(43'hffffffff, '1, 32'h00000003));
    send_item(make_flush());
  endtask

  task automatic test_table_full();
    write_window_length(32'd16);
    for (int i = 0; i < TableEntries; i++)
      send_item(make_trade(43'(i * 5), 20'(i * 7), $urandom));
    send_item(make_trade(43'd3, 20'd0, $urandom));
    send_item(make_trade('1, 20'hfffff, $urandom));
    send_item(make_trade(43'd2000, 20'd3, $urandom));
    send_item(make_flush());
    send_item(make_trade(43'd2000, 20'd3, $urandom));
    send_item(make_flush());
  endtask

  task automatic test_random_phase(logic [31:0] len, int unsigned n_items, bit hold_off);
    logic [TsW-1:0] base_ts[6];
    logic [SymW-1:0] base_sym[6];
    in_item_t it;
    int unsigned pick;
    write_window_length(len);
    foreach (base_ts[i]) begin
      base_ts[i] = 43'({$urandom, $urandom});
      base_sym[i] = 20'($urandom);
    end
    for (int n = 0; n < n_items; n++) begin
      if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (hold_off && n == n_items / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        it = make_flush();
      end else if (pick < 12) begin
        it = make_trade(43'({$urandom, $urandom}), 20'($urandom), $urandom);
        it.trade_flag = 1'b0;
      end else if (pick < 27) begin
        it = make_trade(43'({$urandom, $urandom}), 20'($urandom), $urandom);
      end else begin
        it = make_trade(base_ts[$urandom_range(0, 5)] + 43'($urandom_range(0, 40)),
                        base_sym[$urandom_range(0, 5)], $urandom);
      end
      send_item(it);
    end
    no_idle = 1'b0;
    send_item(make_flush());
  endtask

  // result checker
  initial begin
    int unsigned stall;
    out_item_t got;
    out_item_t want;
    out_bus.ready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      got = out_bus.data;
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(got.status), 64'd0);
      end else begin
        want = pending_rows[0];
        pending_rows.delete(0);
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.win_start !== want.win_start)
          report_mismatch("win_start", 64'(got.win_start), 64'(want.win_start));
        if (got.win_end !== want.win_end)
          report_mismatch("win_end", 64'(got.win_end), 64'(want.win_end));
        if (got.group_symbol !== want.group_symbol)
          report_mismatch("group_symbol", 64'(got.group_symbol), 64'(want.group_symbol));
        if (got.average !== want.average)
          report_mismatch("average", 64'(got.average), 64'(want.average));
        if (got.event_count !== want.event_count)
          report_mismatch("event_count", 64'(got.event_count), 64'(want.event_count));
        if (got.last !== want.last) report_mismatch("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tumbling_window_group_average_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data <= '0;
    win_len = WinLenReset;
    grp_used = 0;
    foreach (grp_valid[i]) grp_valid[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_table_full();
    test_random_phase(32'd1, 80, 1'b0);
    test_random_phase(32'd7, 80, 1'b1);
    test_random_phase(32'd1000, 80, 1'b0);
    test_random_phase($urandom, 70, 1'b0);
    test_random_phase(32'hffffffff, 70, 1'b0);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tumbling_window_group_average_top regression: pass");
    end else begin
      $display("tumbling_window_group_average_top regression: fail");
    end
    $finish;
  end
endmodule
